FILE: rtl/uartrx_pkg.sv
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared constants and types for the UART receive ring with RTS flow control.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int WORD_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int OVF_W    = 16;
  localparam int FILL_W   = 10;
  localparam int MARGIN_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // Width of the almost-full sum (fill plus margin)
  localparam int SUM_W = ((CNT_W > MARGIN_W) ? CNT_W : MARGIN_W) + 1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AF_MARGIN = 2'd2;

  localparam logic [MARGIN_W-1:0] AF_MARGIN_RST = 10'd20;
  localparam logic [OVF_W-1:0]    OVF_MAX       = 16'hffff;

  // Status flags decoded from a popped word
  typedef struct packed {
    logic frame_error;
    logic parity_error;
  } uartrx_flags_t;

endpackage

FILE: rtl/uart_rx_ring_with_rts_flow_core.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_with_rts_flow_core
// Receive ring for raw UART words with RTS flow control, overflow counting
// and pop-time frame/parity decode.
// ----------------------------------------------------------------------------
// The result strobe follows in the cycle after a request is accepted, for every opcode.
// The block takes one request per cycle while busy is low; pointers and counters update
// at accept, and the single ring memory takes one write (push) or one read (pop) a cycle.
// The pop data comes from the registered read port and is decoded in the
// result cycle. Reset is synchronous; busy is high for the cycle after reset.
// The receiver cannot stall: each result is presented for one cycle only.
module uart_rx_ring_with_rts_flow_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [uartrx_pkg::OP_W-1:0]       in_opcode,
  input  logic [uartrx_pkg::WORD_W-1:0]     in_rx_word,
  input  logic                              in_downstream_blocked,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uartrx_pkg::CFG_DAT_W-1:0]  cfg_data,
  // result channel
  output logic                              out_strobe,
  output logic                              out_char_valid,
  output logic [uartrx_pkg::CHAR_W-1:0]     out_char_out,
  output logic                              out_frame_error,
  output logic                              out_parity_error,
  output logic [uartrx_pkg::OVF_W-1:0]      out_overflow_report,
  output logic                              out_rts_asserted,
  output logic [uartrx_pkg::FILL_W-1:0]     out_fill_count
);
  import uartrx_pkg::*;

  // Ring memory
  logic [WORD_W-1:0] ring_mem [RING_DEPTH];
  logic [WORD_W-1:0] ram_rdata_r;

  // Control state
  logic [RING_AW-1:0]  wr_idx_r, wr_idx_nxt;
  logic [RING_AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OVF_W-1:0]    dropped_r, dropped_nxt;
  logic                rts_r, rts_nxt;
  logic                busy_r;

  // Configuration
  logic                par_en_r;
  logic                par_odd_r;
  logic [MARGIN_W-1:0] margin_r;

  // Result stage
  logic                res_valid_r;
  logic                res_pop_r, res_pop_nxt;
  logic [OVF_W-1:0]    res_ovf_r, res_ovf_nxt;
  logic                res_rts_r;
  logic [CNT_W-1:0]    res_fill_r;

  logic                accept;
  logic                do_write;
  logic                do_read;
  logic                full;
  logic [CNT_W-1:0]    count_inc;
  logic [SUM_W-1:0]    af_sum;
  uartrx_flags_t       flags;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign full      = (count_r == CNT_W'(RING_DEPTH));
  assign count_inc = count_r + CNT_W'(1);
  assign af_sum    = SUM_W'(count_inc) + SUM_W'(margin_r);

  // Work out the next pointers, counters and RTS level for the request
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    rts_nxt     = rts_r;
    do_write    = 1'b0;
    do_read     = 1'b0;
    res_pop_nxt = 1'b0;
    res_ovf_nxt = '0;
    if (accept) begin
      unique case (in_opcode)
        OP_PUSH: begin
          if (full) begin
            if (dropped_r != OVF_MAX) dropped_nxt = dropped_r + OVF_W'(1);
          end else begin
            do_write   = 1'b1;
            wr_idx_nxt = (wr_idx_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_idx_r + RING_AW'(1);
            count_nxt  = count_inc;
            if (af_sum > SUM_W'(RING_DEPTH)) rts_nxt = 1'b0;
          end
        end
        OP_POP: begin
          if ((count_r != '0) && !in_downstream_blocked) begin
            do_read     = 1'b1;
            rd_idx_nxt  = (rd_idx_r == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_idx_r + RING_AW'(1);
            count_nxt   = count_r - CNT_W'(1);
            res_pop_nxt = 1'b1;
            res_ovf_nxt = dropped_r;
            dropped_nxt = '0;
          end
          if ((count_r == '0) && in_downstream_blocked) rts_nxt = 1'b1;
        end
        OP_FLUSH: begin
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
          count_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Write on push, read on pop
  always_ff @(posedge clk) begin
    if (do_write) ring_mem[wr_idx_r] <= in_rx_word;
    if (do_read) ram_rdata_r <= ring_mem[rd_idx_r];
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      dropped_r   <= '0;
      rts_r       <= 1'b1;
      busy_r      <= 1'b1;
      res_valid_r <= 1'b0;
      res_pop_r   <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      rts_r       <= rts_nxt;
      busy_r      <= 1'b0;
      res_valid_r <= accept;
      res_pop_r   <= res_pop_nxt;
    end
  end

  // Hold the levels after this request for the result cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      res_ovf_r  <= res_ovf_nxt;
      res_rts_r  <= rts_nxt;
      res_fill_r <= count_nxt;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_en_r  <= 1'b0;
      par_odd_r <= 1'b0;
      margin_r  <= AF_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PARITY_EN:  par_en_r  <= cfg_data[0];
        CFG_PARITY_ODD: par_odd_r <= cfg_data[0];
        CFG_AF_MARGIN:  margin_r  <= cfg_data[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uartrx_decode u_decode (
    .word          (ram_rdata_r),
    .parity_enable (par_en_r),
    .parity_odd    (par_odd_r),
    .flags         (flags)
  );

  // Drive the result; popped fields read zero for other requests
  assign out_strobe          = res_valid_r;
  assign out_char_valid      = res_pop_r;
  assign out_char_out        = res_pop_r ? ram_rdata_r[CHAR_W-1:0] : '0;
  assign out_frame_error     = res_pop_r & flags.frame_error;
  assign out_parity_error    = res_pop_r & flags.parity_error;
  assign out_overflow_report = res_ovf_r;
  assign out_rts_asserted    = res_rts_r;
  assign out_fill_count      = FILL_W'(res_fill_r);

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_DEPTH))
    else $error("ring fill above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("missing result after request");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe)
    else $error("result without request");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    do_read |-> (count_r != '0) && (in_opcode == OP_POP))
    else $error("read issued on empty ring");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> count_r == $past(count_inc))
    else $error("fill not advanced by push");
`endif

endmodule

FILE: rtl/uartrx_decode.sv
// ----------------------------------------------------------------------------
// uartrx_decode
// Decode break/frame and parity flags from a raw received word.
// ----------------------------------------------------------------------------
module uartrx_decode (
  input  logic [uartrx_pkg::WORD_W-1:0] word,
  input  logic                          parity_enable,
  input  logic                          parity_odd,
  output uartrx_pkg::uartrx_flags_t     flags
);
  import uartrx_pkg::*;

  logic brk;

  // Flag a break when the low nine bits are all zero
  assign brk = (word[8:0] == 9'd0);

  // Check bit seven against the low seven bits; a break masks the check
  always_comb begin
    flags.frame_error  = brk;
    flags.parity_error = parity_enable & ~brk & ((^word[CHAR_W-1:0]) ^ parity_odd);
  end

endmodule

FILE: test/uartrx_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrx_ring_checker
// Watches the request, configuration and result channels of the UART receive
// ring, keeps its own copy of the ring and flow-control state, works out the
// result due for every accepted request and compares each strobed result,
// field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module uartrx_ring_checker
  import uartrx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [WORD_W-1:0]    in_rx_word,
  input  logic                 in_downstream_blocked,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 out_strobe,
  input  logic                 out_char_valid,
  input  logic [CHAR_W-1:0]    out_char_out,
  input  logic                 out_frame_error,
  input  logic                 out_parity_error,
  input  logic [OVF_W-1:0]     out_overflow_report,
  input  logic                 out_rts_asserted,
  input  logic [FILL_W-1:0]    out_fill_count,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    logic               char_valid;
    logic [CHAR_W-1:0]  char_out;
    logic               frame_error;
    logic               parity_error;
    logic [OVF_W-1:0]   overflow_report;
    logic               rts_asserted;
    logic [FILL_W-1:0]  fill_count;
  } ring_result_t;

  // Mirror of the ring and its flow-control state
  logic [WORD_W-1:0]   ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]  wr_ptr;
  logic [RING_AW-1:0]  rd_ptr;
  logic [CNT_W-1:0]    held;
  logic [OVF_W-1:0]    dropped;
  logic                rts;
  logic                par_en;
  logic                par_odd;
  logic [MARGIN_W-1:0] af_margin;

  ring_result_t due_results[$];
  int           n_fail = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Work out the result of one request and advance the mirrored state
  function automatic ring_result_t apply_ring_request(
    input logic [OP_W-1:0]   op,
    input logic [WORD_W-1:0] word,
    input logic              blocked
  );
    ring_result_t      r;
    logic [WORD_W-1:0] w;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (held >= RING_DEPTH) begin
          // Drop the word; the count saturates
          if (dropped != OVF_MAX) dropped = dropped + 1'b1;
        end else begin
          ring_mem[wr_ptr] = word;
          wr_ptr = wr_ptr + 1'b1;
          held = held + 1'b1;
          if (int'(held) + int'(af_margin) > RING_DEPTH) rts = 1'b0;
        end
      end
      OP_POP: begin
        if (held != 0 && !blocked) begin
          w = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          held = held - 1'b1;
          r.char_valid = 1'b1;
          r.char_out   = w[7:0];
          if (w[8:0] == '0) r.frame_error = 1'b1;
          else if (par_en) r.parity_error = w[7] ^ (^w[6:0]) ^ par_odd;
          r.overflow_report = dropped;
          dropped = '0;
        end
        // Reassert RTS once drained while the consumer holds off
        if (held == 0 && blocked) rts = 1'b1;
      end
      OP_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
        held   = '0;
      end
      default: begin
      end
    endcase
    r.rts_asserted = rts;
    r.fill_count   = held;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_channels
    ring_result_t want;
    if (!rst_n) begin
      wr_ptr    = '0;
      rd_ptr    = '0;
      held      = '0;
      dropped   = '0;
      rts       = 1'b1;
      par_en    = 1'b0;
      par_odd   = 1'b0;
      af_margin = AF_MARGIN_RST;
      due_results.delete();
    end else begin
      // Compare the result that ends this cycle
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          n_fail++;
          $display("%0t: result mismatch, expected none, actual fill %0h",
                   $time, out_fill_count);
        end else begin
          want = due_results.pop_front();
          check_field("char_valid", want.char_valid, out_char_valid);
          check_field("char_out", want.char_out, out_char_out);
          check_field("frame_error", want.frame_error, out_frame_error);
          check_field("parity_error", want.parity_error, out_parity_error);
          check_field("overflow_report", want.overflow_report, out_overflow_report);
          check_field("rts_asserted", want.rts_asserted, out_rts_asserted);
          check_field("fill_count", want.fill_count, out_fill_count);
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PARITY_EN:  par_en    = cfg_data[0];
          CFG_PARITY_ODD: par_odd   = cfg_data[0];
          CFG_AF_MARGIN:  af_margin = cfg_data[MARGIN_W-1:0];
          default: begin
          end
        endcase
      end
      // Predict the accepted request
      if (start && !busy)
        due_results.push_back(apply_ring_request(in_opcode, in_rx_word,
                                                 in_downstream_blocked));
    end
    fail_count    <= n_fail;
    pending_count <= due_results.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the UART receive ring with directed requests, a fill and overflow
// stress run and random request runs over several register settings, with
// bursty request timing; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import uartrx_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_IDLE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int                   IDLE_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_opcode;
  logic [WORD_W-1:0]    in_rx_word;
  logic                 in_downstream_blocked;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 out_strobe;
  logic                 out_char_valid;
  logic [CHAR_W-1:0]    out_char_out;
  logic                 out_frame_error;
  logic                 out_parity_error;
  logic [OVF_W-1:0]     out_overflow_report;
  logic                 out_rts_asserted;
  logic [FILL_W-1:0]    out_fill_count;
  int                   fail_count;
  int                   pending_count;
  int                   idle_cycles = 0;
  int                   burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uart_rx_ring_with_rts_flow_core i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_rx_word            (in_rx_word),
    .in_downstream_blocked (in_downstream_blocked),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_char_valid        (out_char_valid),
    .out_char_out          (out_char_out),
    .out_frame_error       (out_frame_error),
    .out_parity_error      (out_parity_error),
    .out_overflow_report   (out_overflow_report),
    .out_rts_asserted      (out_rts_asserted),
    .out_fill_count        (out_fill_count)
  );

  uartrx_ring_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_rx_word            (in_rx_word),
    .in_downstream_blocked (in_downstream_blocked),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_char_valid        (out_char_valid),
    .out_char_out          (out_char_out),
    .out_frame_error       (out_frame_error),
    .out_parity_error      (out_parity_error),
    .out_overflow_report   (out_overflow_report),
    .out_rts_asserted      (out_rts_asserted),
    .out_fill_count        (out_fill_count),
    .fail_count            (fail_count),
    .pending_count         (pending_count)
  );

  // Abort when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Issue one request, idling between bursts, and hold it until accepted
  task automatic send_req(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                          input logic blocked);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    start                 <= 1'b1;
    in_opcode             <= op;
    in_rx_word            <= word;
    in_downstream_blocked <= blocked;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for every request still due to come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Present one register write and hold it until taken; caller drops valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic pe, input logic po, input logic [MARGIN_W-1:0] margin);
    write_reg(CFG_PARITY_EN, {9'($urandom_range(0, 511)), pe});
    write_reg(CFG_PARITY_ODD, {9'($urandom_range(0, 511)), po});
    write_reg(CFG_AF_MARGIN, margin);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    if ($urandom_range(0, 4) == 0) return {7'($urandom_range(0, 127)), 9'h000};
    return 16'($urandom_range(0, 65535));
  endfunction

  // Runs of pushes, runs of pops and mixed noise with random content
  task automatic run_random(input int n_items);
    int done;
    int kind;
    int run_len;
    int pick;
    logic [OP_W-1:0] op;
    done = 0;
    while (done < n_items) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && done < n_items; k++) begin
        if (kind < 4) op = OP_PUSH;
        else if (kind < 8) op = OP_POP;
        else begin
          pick = $urandom_range(0, 19);
          if (pick == 0) op = OP_FLUSH;
          else if (pick == 1) op = OP_IDLE;
          else if (pick < 11) op = OP_PUSH;
          else op = OP_POP;
        end
        send_req(op, rand_word(), $urandom_range(0, 3) == 0);
        done++;
      end
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    start                 <= 1'b0;
    in_opcode             <= OP_PUSH;
    in_rx_word            <= '0;
    in_downstream_blocked <= 1'b0;
    cfg_valid             <= 1'b0;
    cfg_index             <= CFG_PARITY_EN;
    cfg_data              <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pops, no-op, break and edge words at reset settings
    send_req(OP_POP, 16'h0000, 1'b0);
    send_req(OP_POP, 16'hffff, 1'b1);
    send_req(OP_IDLE, 16'h5a5a, 1'b0);
    send_req(OP_PUSH, 16'h0000, 1'b0);
    send_req(OP_PUSH, 16'hffff, 1'b1);
    send_req(OP_PUSH, 16'h0100, 1'b0);
    send_req(OP_PUSH, 16'hfe00, 1'b0);
    send_req(OP_PUSH, 16'h00ff, 1'b0);
    send_req(OP_POP, 16'h0000, 1'b1);
    repeat (5) send_req(OP_POP, 16'h0000, 1'b0);
    send_req(OP_PUSH, 16'h1234, 1'b0);
    send_req(OP_PUSH, 16'h00aa, 1'b0);
    send_req(OP_FLUSH, 16'h0000, 1'b0);
    send_req(OP_POP, 16'h0000, 1'b0);
    wait_idle();

    // Directed: odd parity, zero margin, spare register index
    set_config(1'b1, 1'b1, 10'd0);
    write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
    send_req(OP_PUSH, 16'h0080, 1'b0);
    send_req(OP_PUSH, 16'h0001, 1'b0);
    send_req(OP_PUSH, 16'h0081, 1'b0);
    send_req(OP_PUSH, 16'h7f7f, 1'b0);
    send_req(OP_PUSH, 16'h0000, 1'b0);
    repeat (5) send_req(OP_POP, 16'h0000, 1'b0);
    wait_idle();

    // Stress: offset the pointers, fill past the wrap, drop words when full
    set_config(1'b0, 1'b0, 10'h3ff);
    repeat (20) send_req(OP_PUSH, rand_word(), 1'b0);
    repeat (20) send_req(OP_POP, 16'h0000, 1'b0);
    repeat (RING_DEPTH) send_req(OP_PUSH, rand_word(), $urandom_range(0, 1) == 1);
    repeat (10) send_req(OP_PUSH, rand_word(), 1'b0);
    send_req(OP_POP, 16'h0000, 1'b1);
    repeat (20) send_req(OP_POP, 16'h0000, 1'b0);
    send_req(OP_POP, 16'h0000, 1'b1);
    send_req(OP_FLUSH, 16'h0000, 1'b0);
    wait_idle();

    // Random runs over several settings, extremes first
    set_config(1'b0, 1'b0, 10'd0);
    run_random(48);
    wait_idle();
    set_config(1'b1, 1'b0, 10'd512);
    run_random(48);
    wait_idle();
    set_config(1'b1, 1'b1, 10'd1);
    run_random(48);
    wait_idle();
    set_config(1'b0, 1'b1, 10'($urandom_range(0, 1023)));
    run_random(48);
    wait_idle();
    set_config(1'b1, 1'($urandom_range(0, 1)), 10'($urandom_range(490, 530)));
    run_random(48);
    wait_idle();

    // Let the last results settle, then give the verdict
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
